// ===== rtl/core/nv21i_pkg.sv =====
// ----------------------------------------------------------------------------
// nv21i_pkg
// Shared codes, widths and types of the NV21 to I420 crop and rotate core.
// ----------------------------------------------------------------------------
package nv21i_pkg;

    // Fixed field widths of the ports.
    localparam int C_ROW_W   = 10;
    localparam int C_COL_W   = 10;
    localparam int C_DATA_W  = 8;
    localparam int C_PLANE_W = 2;
    localparam int C_CFG_IW  = 3;
    localparam int C_CFG_DW  = 10;

    // Width of the signed coordinate arithmetic inside the core.
    localparam int C_VW = 14;

    typedef logic signed [C_VW-1:0] t_sval;

    // Configuration register indexes.
    typedef enum logic [C_CFG_IW-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_OUT_WIDTH  = 3'd2,
        CFG_OUT_HEIGHT = 3'd3,
        CFG_ROTATION   = 3'd4
    } t_cfg_idx;

    // Request kinds.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // Output planes.
    localparam logic [C_PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [C_PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [C_PLANE_W-1:0] PLANE_V = 2'd2;

    // Rotation codes, clockwise.
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

endpackage

// ===== rtl/core/nv21_to_i420_crop_rotate_core.sv =====
// A fetch word passes the input, map, check, address and store registers.
// Throughput: one word per cycle while the output is not held, loads and
// fetches alike; the frame store has a single port, used in the memory stage.
// Reset: synchronous, active low; it clears the stage valid bits and loads
// the register defaults. The frame store is not cleared.
// ----------------------------------------------------------------------------
// nv21_to_i420_crop_rotate_core
// Stores an NV21 frame byte by byte and returns bytes of an I420 view of it
// after a centered crop and a rotation by a multiple of 90 degrees.
// ----------------------------------------------------------------------------
module nv21_to_i420_crop_rotate_core #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_we,
    input  logic [nv21i_pkg::C_CFG_IW-1:0]   i_cfg_idx,
    input  logic [nv21i_pkg::C_CFG_DW-1:0]   i_cfg_data,
    // Request channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_req_type,
    input  logic [nv21i_pkg::C_PLANE_W-1:0]  i_plane,
    input  logic [nv21i_pkg::C_ROW_W-1:0]    i_row,
    input  logic [nv21i_pkg::C_COL_W-1:0]    i_col,
    input  logic [nv21i_pkg::C_DATA_W-1:0]   i_data,
    // Result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [nv21i_pkg::C_DATA_W-1:0]   o_pixel
);

    import nv21i_pkg::*;

    localparam int STORE_ROWS = MAX_HEIGHT / 2 * 3;
    localparam int STORE_SIZE = MAX_WIDTH * STORE_ROWS;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int SROW_W     = $clog2(STORE_ROWS);
    localparam int SCOL_W     = $clog2(MAX_WIDTH);

    localparam t_sval ONE = 14'sd1;
    localparam t_sval TWO = 14'sd2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [9:0] r_src_width;
    logic [8:0] r_src_height;
    logic [9:0] r_out_width;
    logic [9:0] r_out_height;
    logic [1:0] r_rotation;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= 10'd640;
            r_src_height <= 9'd480;
            r_out_width  <= 10'd640;
            r_out_height <= 10'd480;
            r_rotation   <= ROT_0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[8:0];
                CFG_OUT_WIDTH:  r_out_width  <= i_cfg_data;
                CFG_OUT_HEIGHT: r_out_height <= i_cfg_data;
                CFG_ROTATION:   r_rotation   <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    t_sval s_sw, s_sh, s_ow, s_oh;
    assign s_sw = {4'b0, r_src_width};
    assign s_sh = {5'b0, r_src_height};
    assign s_ow = {4'b0, r_out_width};
    assign s_oh = {4'b0, r_out_height};

    // ------------------------------------------------------------------
    // Crop offsets and chroma bounds, derived from the registers.
    // Halving rounds toward zero, as signed integer division does.
    // ------------------------------------------------------------------
    t_sval n_dw, n_dh, n_dh2, n_cbase, n_cr1, n_sc3, n_sh3, n_pw, n_ph;
    t_sval d_cw, d_ch, d_diff_w, d_diff_h, d_tw, d_th, d_th2, d_shh;

    always_comb begin
        d_cw     = r_rotation[0] ? s_oh : s_ow;
        d_ch     = r_rotation[0] ? s_ow : s_oh;
        d_diff_w = s_sw - d_cw;
        d_diff_h = s_sh - d_ch;
        d_tw     = d_diff_w + {{(C_VW-1){1'b0}}, d_diff_w[C_VW-1]};
        d_th     = d_diff_h + {{(C_VW-1){1'b0}}, d_diff_h[C_VW-1]};
        n_dw     = d_tw >>> 1;
        n_dh     = d_th >>> 1;
        d_th2    = n_dh + {{(C_VW-1){1'b0}}, n_dh[C_VW-1]};
        n_dh2    = d_th2 >>> 1;
        d_shh    = s_sh >>> 1;
        n_sh3    = d_shh + d_shh + d_shh;
        n_cbase  = s_sh + n_dh2;
        n_cr1    = n_sh3 - n_dh2 - ONE;
        n_sc3    = s_sw - n_dw - TWO;
        n_pw     = s_ow >>> 1;
        n_ph     = s_oh >>> 1;
    end

    t_sval r_dw, r_dh, r_cbase, r_cr1, r_sc3, r_sh3, r_pw, r_ph;

    always_ff @(posedge i_clk) begin
        r_dw    <= n_dw;
        r_dh    <= n_dh;
        r_cbase <= n_cbase;
        r_cr1   <= n_cr1;
        r_sc3   <= n_sc3;
        r_sh3   <= n_sh3;
        r_pw    <= n_pw;
        r_ph    <= n_ph;
    end

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless the output word is held.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en;

    assign w_en    = !(r_v5 && i_stall);
    assign o_stall = !w_en;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic                 r_req1;
    logic [C_PLANE_W-1:0] r_plane1;
    logic [C_ROW_W-1:0]   r_row1;
    logic [C_COL_W-1:0]   r_col1;
    logic [C_DATA_W-1:0]  r_data1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_req1   <= i_req_type;
            r_plane1 <= i_plane;
            r_row1   <= i_row;
            r_col1   <= i_col;
            r_data1  <= i_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: map the output position back to a source position.
    // ------------------------------------------------------------------
    t_sval s_r, s_c, s_u;
    t_sval n_sr2, n_sc2, n_lo2, n_hi2;
    logic  n_zero2;
    logic  w_chroma;

    always_comb begin
        s_r      = {4'b0, r_row1};
        s_c      = {4'b0, r_col1};
        s_u      = {{(C_VW-1){1'b0}}, r_plane1 == PLANE_U};
        w_chroma = (r_plane1 == PLANE_U) || (r_plane1 == PLANE_V);
        n_sr2    = s_r;
        n_sc2    = s_c;
        n_lo2    = '0;
        n_hi2    = s_sh;
        n_zero2  = 1'b0;
        if (r_req1 == REQ_FETCH) begin
            if (!w_chroma) begin
                // Luma plane, or the unused fourth plane code.
                n_zero2 = (r_plane1 != PLANE_Y) || (s_r >= s_oh) || (s_c >= s_ow);
                case (r_rotation)
                    ROT_0: begin
                        n_sr2 = r_dh + s_r;
                        n_sc2 = r_dw + s_c;
                    end
                    ROT_90: begin
                        n_sr2 = r_dh + s_ow - ONE - s_c;
                        n_sc2 = r_dw + s_r;
                    end
                    ROT_180: begin
                        n_sr2 = r_dh + s_oh - ONE - s_r;
                        n_sc2 = r_dw + s_ow - ONE - s_c;
                    end
                    default: begin
                        n_sr2 = r_dh + s_c;
                        n_sc2 = r_dw + s_oh - ONE - s_r;
                    end
                endcase
            end else begin
                // Chroma: rows follow the luma rows, U and V interleave.
                n_zero2 = (s_r >= r_ph) || (s_c >= r_pw);
                n_lo2   = s_sh;
                n_hi2   = r_sh3;
                case (r_rotation)
                    ROT_0: begin
                        n_sr2 = r_cbase + s_r;
                        n_sc2 = r_dw + s_c + s_c + s_u;
                    end
                    ROT_90: begin
                        n_sr2 = r_cr1 - s_c;
                        n_sc2 = r_dw + s_r + s_r + s_u;
                    end
                    ROT_180: begin
                        n_sr2 = r_cbase + r_ph - ONE - s_r;
                        n_sc2 = r_dw + r_pw + r_pw - TWO - s_c - s_c + s_u;
                    end
                    default: begin
                        n_sr2 = r_cbase + s_c;
                        n_sc2 = r_sc3 - s_r - s_r + s_u;
                    end
                endcase
            end
        end
    end

    logic                r_req2, r_zero2;
    t_sval               r_sr2, r_sc2, r_lo2, r_hi2;
    logic [C_DATA_W-1:0] r_data2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_req2  <= r_req1;
            r_zero2 <= n_zero2;
            r_sr2   <= n_sr2;
            r_sc2   <= n_sc2;
            r_lo2   <= n_lo2;
            r_hi2   <= n_hi2;
            r_data2 <= r_data1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: range checks against the source frame and the store.
    // ------------------------------------------------------------------
    logic w_in_store, w_in_frame, n_ok3;

    always_comb begin
        w_in_store = !r_sr2[C_VW-1] && !r_sc2[C_VW-1] &&
                     (int'(r_sr2) < STORE_ROWS) && (int'(r_sc2) < MAX_WIDTH);
        w_in_frame = !r_zero2 && (r_sr2 >= r_lo2) && (r_sr2 < r_hi2) &&
                     !r_sc2[C_VW-1] && (r_sc2 < s_sw);
        n_ok3      = w_in_store && ((r_req2 == REQ_LOAD) || w_in_frame);
    end

    logic                r_req3, r_ok3;
    logic [SROW_W-1:0]   r_row3;
    logic [SCOL_W-1:0]   r_col3;
    logic [C_DATA_W-1:0] r_data3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_req3  <= r_req2;
            r_ok3   <= n_ok3;
            r_row3  <= r_sr2[SROW_W-1:0];
            r_col3  <= r_sc2[SCOL_W-1:0];
            r_data3 <= r_data2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: linear store address.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] n_addr4;

    assign n_addr4 = ADDR_W'(ADDR_W'(r_row3) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_col3));

    logic                r_req4, r_ok4;
    logic [ADDR_W-1:0]   r_addr4;
    logic [C_DATA_W-1:0] r_data4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_req4  <= r_req3;
            r_ok4   <= r_ok3;
            r_addr4 <= n_addr4;
            r_data4 <= r_data3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: frame store access, single port, registered read data.
    // ------------------------------------------------------------------
    logic [C_DATA_W-1:0] r_frame_store [STORE_SIZE];
    logic [C_DATA_W-1:0] r_q5;
    logic                r_ok5;

    always_ff @(posedge i_clk) begin
        if (w_en && r_v4 && r_ok4) begin
            if (r_req4 == REQ_LOAD) begin
                r_frame_store[r_addr4] <= r_data4;
            end else begin
                r_q5 <= r_frame_store[r_addr4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= r_v4 && (r_req4 == REQ_FETCH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ok5 <= r_ok4;
        end
    end

    // A fetch outside the plane or the source frame returns zero.
    assign o_valid = r_v5;
    assign o_pixel = r_ok5 ? r_q5 : '0;

endmodule

// ===== rtl/core/nv21i_chk.sv =====
// ----------------------------------------------------------------------------
// nv21i_chk
// Port-level checks of the crop and rotate core, bound to the top level.
// ----------------------------------------------------------------------------
module nv21i_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic                             i_req_type,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [nv21i_pkg::C_DATA_W-1:0]   o_pixel
);

    import nv21i_pkg::*;

    // The input side is held back only while a result word is held back.
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow the held output word");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word present right after reset");

    // A held result word stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel))
        else $error("held result word changed");

    // A fetch reaches the output through the pipeline registers when nothing stalls.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_req_type == REQ_FETCH)
        ##1 !i_stall ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("fetch result missing after pipeline latency");

endmodule

bind nv21_to_i420_crop_rotate_core nv21i_chk u_nv21i_chk (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NV21 to I420 crop and rotate core. Loads fill a
// private copy of the frame store, and each fetch word is predicted from the
// current crop, rotation and stored bytes. A short directed list comes first.
// Random phases follow, one register setting each, under random sender gaps
// and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import nv21i_pkg::*;

    localparam int MAX_W       = 640;
    localparam int MAX_H       = 480;
    localparam int STORE_ROWS  = MAX_H / 2 * 3;
    localparam int STORE_SIZE  = MAX_W * STORE_ROWS;
    localparam int PIPE_LAT    = 4;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int WORD_TARGET = 1900;

    // The fourth plane code selects no plane and always returns zero.
    localparam logic [C_PLANE_W-1:0] PLANE_NONE = 2'd3;

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    // One row of the directed list; pixel is used only where typed is set.
    typedef struct packed {
        logic                 req;
        logic [C_PLANE_W-1:0] plane;
        logic [C_ROW_W-1:0]   row;
        logic [C_COL_W-1:0]   col;
        logic [C_DATA_W-1:0]  data;
        logic                 typed;
        logic [C_DATA_W-1:0]  pixel;
    } t_dir_word;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [C_CFG_IW-1:0]  i_cfg_idx  = '0;
    logic [C_CFG_DW-1:0]  i_cfg_data = '0;
    logic                 i_valid    = 1'b0;
    logic                 o_stall;
    logic                 i_req_type = REQ_LOAD;
    logic [C_PLANE_W-1:0] i_plane    = PLANE_Y;
    logic [C_ROW_W-1:0]   i_row      = '0;
    logic [C_COL_W-1:0]   i_col      = '0;
    logic [C_DATA_W-1:0]  i_data     = '0;
    logic                 o_valid;
    logic                 i_stall    = 1'b0;
    logic [C_DATA_W-1:0]  o_pixel;

    // Private copy of the frame store and of the registers.
    logic [7:0] frame_mem [STORE_SIZE];
    bit         loaded    [STORE_SIZE];
    int         cfg_sw  = 640;
    int         cfg_sh  = 480;
    int         cfg_ow  = 640;
    int         cfg_oh  = 480;
    logic [1:0] cfg_rot = ROT_0;

    logic [7:0] pending_pixels [$];
    int         err_count   = 0;
    int         word_count  = 0;
    int         cycle_count = 0;
    int         burst_left  = 0;

    t_stall_mode stall_mode   = STALL_NONE;
    int          stall_left   = 0;
    int          stall_period = 2;

    // Reset-time register values give no crop, so every luma entry reads straight
    // from its own store address; chroma entries read from row 480 on.
    t_dir_word directed_words [23] = '{
        '{REQ_LOAD,  PLANE_Y,    10'd0,    10'd0,    8'hA5, 1'b0, 8'h00},
        '{REQ_LOAD,  PLANE_NONE, 10'd479,  10'd639,  8'h5A, 1'b0, 8'h00},
        '{REQ_LOAD,  PLANE_U,    10'd480,  10'd0,    8'h11, 1'b0, 8'h00},
        '{REQ_LOAD,  PLANE_V,    10'd480,  10'd1,    8'h22, 1'b0, 8'h00},
        '{REQ_LOAD,  PLANE_Y,    10'd719,  10'd638,  8'hFF, 1'b0, 8'h00},
        '{REQ_LOAD,  PLANE_NONE, 10'd719,  10'd639,  8'h00, 1'b0, 8'h00},
        '{REQ_LOAD,  PLANE_Y,    10'd1,    10'd0,    8'h3C, 1'b0, 8'h00},
        // Loads outside the store must leave it untouched.
        '{REQ_LOAD,  PLANE_Y,    10'd720,  10'd0,    8'h77, 1'b0, 8'h00},
        '{REQ_LOAD,  PLANE_Y,    10'd0,    10'd640,  8'h66, 1'b0, 8'h00},
        '{REQ_LOAD,  PLANE_NONE, 10'd1023, 10'd1023, 8'hFF, 1'b0, 8'h00},
        '{REQ_FETCH, PLANE_Y,    10'd0,    10'd0,    8'hFF, 1'b1, 8'hA5},
        '{REQ_FETCH, PLANE_Y,    10'd479,  10'd639,  8'h00, 1'b1, 8'h5A},
        '{REQ_FETCH, PLANE_Y,    10'd1,    10'd0,    8'h00, 1'b1, 8'h3C},
        '{REQ_FETCH, PLANE_U,    10'd0,    10'd0,    8'h00, 1'b1, 8'h22},
        '{REQ_FETCH, PLANE_V,    10'd0,    10'd0,    8'h00, 1'b1, 8'h11},
        '{REQ_FETCH, PLANE_U,    10'd239,  10'd319,  8'h00, 1'b1, 8'h00},
        '{REQ_FETCH, PLANE_V,    10'd239,  10'd319,  8'h00, 1'b1, 8'hFF},
        '{REQ_FETCH, PLANE_NONE, 10'd0,    10'd0,    8'h00, 1'b1, 8'h00},
        '{REQ_FETCH, PLANE_Y,    10'd480,  10'd0,    8'h00, 1'b1, 8'h00},
        '{REQ_FETCH, PLANE_Y,    10'd0,    10'd640,  8'h00, 1'b1, 8'h00},
        '{REQ_FETCH, PLANE_U,    10'd240,  10'd0,    8'h00, 1'b1, 8'h00},
        '{REQ_FETCH, PLANE_V,    10'd0,    10'd320,  8'h00, 1'b1, 8'h00},
        '{REQ_FETCH, PLANE_NONE, 10'd1023, 10'd1023, 8'hFF, 1'b1, 8'h00}
    };

    nv21_to_i420_crop_rotate_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_plane    (i_plane),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pixel    (o_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Map an output position back to a store address. The hit flag is clear
    // when the fetch returns zero without reading the store.
    function automatic void map_fetch(input logic [1:0] pl, input int r, input int c,
                                      output bit hit, output int addr);
        int  dw, dh, sr, sc, pw, ph, base, rlo, rhi, u;
        bit  sideways;
        hit      = 1'b0;
        addr     = 0;
        sideways = cfg_rot[0];
        if (pl == PLANE_NONE)
            return;
        // Signed division truncates toward zero, as the crop offsets require.
        dw = (cfg_sw - (sideways ? cfg_oh : cfg_ow)) / 2;
        dh = (cfg_sh - (sideways ? cfg_ow : cfg_oh)) / 2;
        if (pl == PLANE_Y) begin
            if (r >= cfg_oh || c >= cfg_ow)
                return;
            case (cfg_rot)
                ROT_0: begin
                    sr = dh + r;
                    sc = dw + c;
                end
                ROT_90: begin
                    sr = dh + cfg_ow - 1 - c;
                    sc = dw + r;
                end
                ROT_180: begin
                    sr = dh + cfg_oh - 1 - r;
                    sc = dw + cfg_ow - 1 - c;
                end
                default: begin
                    sr = dh + c;
                    sc = dw + cfg_oh - 1 - r;
                end
            endcase
            rlo = 0;
            rhi = cfg_sh;
        end else begin
            pw   = cfg_ow / 2;
            ph   = cfg_oh / 2;
            base = cfg_sh + dh / 2;
            if (r >= ph || c >= pw)
                return;
            // U sits on the odd byte of each interleaved chroma pair.
            u = (pl == PLANE_U) ? 1 : 0;
            case (cfg_rot)
                ROT_0: begin
                    sr = base + r;
                    sc = dw + 2 * c + u;
                end
                ROT_90: begin
                    sr = cfg_sh / 2 * 3 - dh / 2 - 1 - c;
                    sc = dw + 2 * r + u;
                end
                ROT_180: begin
                    sr = base + ph - 1 - r;
                    sc = dw + 2 * (pw - 1 - c) + u;
                end
                default: begin
                    sr = base + c;
                    sc = cfg_sw - dw - 2 - 2 * r + u;
                end
            endcase
            rlo = cfg_sh;
            rhi = cfg_sh / 2 * 3;
        end
        if (sr < rlo || sr >= rhi || sc < 0 || sc >= cfg_sw)
            return;
        if (sr >= STORE_ROWS || sc >= MAX_W)
            return;
        hit  = 1'b1;
        addr = sr * MAX_W + sc;
    endfunction

    function automatic logic [7:0] predict_pixel(input logic [1:0] pl, input logic [9:0] r,
                                                 input logic [9:0] c);
        bit hit;
        int addr;
        map_fetch(pl, int'(r), int'(c), hit, addr);
        return hit ? frame_mem[addr] : 8'd0;
    endfunction

    // Drive one word and hold it until the core takes it, then update the
    // private store or queue the expected pixel. A random gap, possibly none, opens each new burst.
    task automatic send_word(input logic req, input logic [1:0] pl, input logic [9:0] r,
                             input logic [9:0] c, input logic [7:0] d,
                             input bit typed, input logic [7:0] typed_pixel);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_plane    <= pl;
        i_row      <= r;
        i_col      <= c;
        i_data     <= d;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (req == REQ_LOAD) begin
            if (int'(r) < STORE_ROWS && int'(c) < MAX_W) begin
                frame_mem[int'(r) * MAX_W + int'(c)] = d;
                loaded[int'(r) * MAX_W + int'(c)]    = 1'b1;
                word_count++;
            end
        end else begin
            pending_pixels.push_back(typed ? typed_pixel : predict_pixel(pl, r, c));
            word_count++;
        end
    endtask

    // A fetch that would read a store entry never written gets a load there
    // first, so every fetch reads defined data.
    task automatic fetch_at(input logic [1:0] pl, input int r, input int c);
        bit hit;
        int addr;
        map_fetch(pl, r, c, hit, addr);
        if (hit && !loaded[addr])
            send_word(REQ_LOAD, 2'($urandom_range(0, 3)), 10'(addr / MAX_W),
                      10'(addr % MAX_W), 8'($urandom_range(0, 255)), 1'b0, 8'd0);
        send_word(REQ_FETCH, pl, 10'(r), 10'(c), 8'($urandom_range(0, 255)), 1'b0, 8'd0);
    endtask

    // Stop sending and let every expected pixel and any trailing load drain.
    task automatic drain_core();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (2 * PIPE_LAT) @(posedge i_clk);
    endtask

    // Write all five registers on consecutive cycles while the core is idle.
    task automatic set_config(input int sw, input int sh, input int ow, input int oh,
                              input logic [1:0] rot);
        t_cfg_idx idx  [5];
        int       vals [5];
        idx  = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_OUT_WIDTH, CFG_OUT_HEIGHT, CFG_ROTATION};
        vals = '{sw, sh, ow, oh, int'(rot)};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= C_CFG_DW'(vals[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_sw  = sw;
        cfg_sh  = sh;
        cfg_ow  = ow;
        cfg_oh  = oh;
        cfg_rot = rot;
    endtask

    // Random traffic under the current setting: mostly fetches inside the
    // output planes and row scans, plus loads and out-of-range noise.
    task automatic run_phase(input int n_words);
        int         stop_at, pick, r, c, len;
        logic [1:0] pl;
        stop_at = word_count + n_words;
        while (word_count < stop_at) begin
            pick = $urandom_range(0, 99);
            pl   = 2'($urandom_range(0, 2));
            if (pick < 60) begin
                if (pl == PLANE_Y) begin
                    r = $urandom_range(0, cfg_oh - 1);
                    c = $urandom_range(0, cfg_ow - 1);
                end else begin
                    r = $urandom_range(0, cfg_oh / 2 - 1);
                    c = $urandom_range(0, cfg_ow / 2 - 1);
                end
                if (pick < 45) begin
                    fetch_at(pl, r, c);
                end else begin
                    len = $urandom_range(2, 8);
                    for (int j = 0; j < len; j++)
                        fetch_at(pl, r, (c + j) % 1024);
                end
            end else if (pick < 78) begin
                send_word(REQ_LOAD, 2'($urandom_range(0, 3)),
                          10'($urandom_range(0, cfg_sh / 2 * 3 - 1)),
                          10'($urandom_range(0, cfg_sw - 1)),
                          8'($urandom_range(0, 255)), 1'b0, 8'd0);
            end else if (pick < 90) begin
                fetch_at(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                         $urandom_range(0, 1023));
            end else begin
                send_word(REQ_LOAD, 2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                          10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                          1'b0, 8'd0);
            end
        end
    endtask

    // Receiver back-pressure: modes of random length, from none to heavy.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode   = t_stall_mode'($urandom_range(0, 3));
            stall_left   = $urandom_range(16, 160);
            stall_period = $urandom_range(2, 5);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:     i_stall <= 1'b0;
            STALL_SPARSE:   i_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: i_stall <= (stall_left % stall_period == 0);
            default:        i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Compare each accepted pixel with the oldest expectation.
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel: unexpected word, actual %0d", o_pixel);
                err_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel !== want) begin
                    $error("pixel mismatch: expected %0d, actual %0d", want, o_pixel);
                    err_count++;
                end
            end
        end
    end

    // Hard stop in case the core hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int phase;
        logic [1:0] rot;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the register defaults.
        foreach (directed_words[k])
            send_word(directed_words[k].req, directed_words[k].plane, directed_words[k].row,
                      directed_words[k].col, directed_words[k].data,
                      directed_words[k].typed, directed_words[k].pixel);
        drain_core();

        // Extreme settings: smallest frame, output taller than the source,
        // smallest crop of the largest frame, and an output far larger.
        set_config(2, 2, 2, 2, ROT_0);
        run_phase(60);
        drain_core();
        set_config(640, 480, 640, 640, ROT_90);
        run_phase(60);
        drain_core();
        set_config(640, 480, 2, 2, ROT_180);
        run_phase(60);
        drain_core();
        set_config(2, 2, 640, 640, ROT_270);
        run_phase(60);
        drain_core();

        // Random settings, stepping through all rotations.
        phase = 0;
        while (word_count < WORD_TARGET) begin
            rot = 2'(phase % 4);
            if ($urandom_range(0, 1) == 0)
                set_config(2 * $urandom_range(1, 20), 2 * $urandom_range(1, 16),
                           2 * $urandom_range(1, 20), 2 * $urandom_range(1, 20), rot);
            else
                set_config(2 * $urandom_range(1, 320), 2 * $urandom_range(1, 240),
                           2 * $urandom_range(1, 320), 2 * $urandom_range(1, 320), rot);
            run_phase($urandom_range(100, 200));
            drain_core();
            phase++;
        end

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/nv21i_pkg.sv
rtl/core/nv21_to_i420_crop_rotate_core.sv
rtl/core/nv21i_chk.sv
test/tb_top.sv
